// ----- rtl/core/b64dd_pkg.sv -----
package b64dd_pkg;

  localparam int GROUP_COUNT_BITS_DEF = 14;
  localparam int QUEUE_DEPTH_DEF      = 2;
  localparam int CFG_DATA_BITS        = 16;
  localparam int SEXTET_BITS          = 6;
  localparam int GROUP_BITS           = 24;

  localparam logic CFG_ORDER    = 1'b0;
  localparam logic CFG_REQ_BITS = 1'b1;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       bad;
    logic       last;
  } grp_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'b1000000;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2d) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64dd_front.sv -----
module b64dd_front import b64dd_pkg::*; #(
  parameter int GROUP_COUNT_BITS = GROUP_COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               char_code,
  input  logic                     final_char,
  input  logic                     char_valid,
  output logic                     char_stall,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     q_full,
  output logic                     push,
  output grp_t                     push_grp
);

  localparam int CW = (GROUP_COUNT_BITS + 5 > 17) ? GROUP_COUNT_BITS + 5 : 17;

  logic                        big_endian_order;
  logic [CFG_DATA_BITS-1:0]    requested_bits;
  logic [17:0]                 acc;
  logic [1:0]                  held;
  logic [GROUP_COUNT_BITS-1:0] groups;
  logic                        grp_err;

  logic        accept;
  logic [6:0]  sx;
  logic        bad_now;
  logic [CW-1:0] bits_done;
  logic [CW-1:0] bits_after;
  logic [CW-1:0] req_ext;
  logic        limited;
  logic        limit_hit;
  logic        emit;
  logic [23:0] low_word;
  logic [23:0] big_word;
  logic [4:0]  shamt;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;
  assign sx         = char_sextet(char_code);
  assign bad_now    = sx[6];

  // 24 * groups as 16g + 8g
  assign bits_done  = (CW'(groups) << 4) + (CW'(groups) << 3);
  assign bits_after = bits_done + CW'(GROUP_BITS);
  assign req_ext    = CW'(requested_bits);
  assign limited    = (requested_bits != '0);
  assign limit_hit  = limited && (req_ext <= bits_done);
  assign emit       = accept && !limit_hit && (final_char || held == 2'd3);

  assign shamt    = 5'(held) * 5'(SEXTET_BITS);
  assign low_word = {6'b0, acc} | ({18'b0, sx[5:0]} << shamt);
  assign big_word = {low_word[5:0], low_word[11:6], low_word[17:12], low_word[23:18]};

  always_comb begin
    push_grp.bad  = grp_err || bad_now;
    push_grp.last = final_char || (limited && (req_ext <= bits_after));
    if (big_endian_order) begin
      push_grp.byte0 = big_word[23:16];
      push_grp.byte1 = big_word[15:8];
      push_grp.byte2 = big_word[7:0];
    end else begin
      push_grp.byte0 = low_word[7:0];
      push_grp.byte1 = low_word[15:8];
      push_grp.byte2 = low_word[23:16];
    end
  end

  assign push = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian_order <= 1'b0;
      requested_bits   <= '0;
      acc              <= '0;
      held             <= '0;
      groups           <= '0;
      grp_err          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ORDER:    big_endian_order <= cfg_data[0];
          CFG_REQ_BITS: requested_bits   <= cfg_data;
          default:      ;
        endcase
      end
      if (accept) begin
        if (limit_hit) begin
          if (final_char) begin
            acc     <= '0;
            held    <= '0;
            grp_err <= 1'b0;
            groups  <= '0;
          end
        end else if (emit) begin
          acc     <= '0;
          held    <= '0;
          grp_err <= 1'b0;
          if (final_char) begin
            groups <= '0;
          end else if (groups != '1) begin
            groups <= groups + 1'b1;
          end
        end else begin
          acc     <= low_word[17:0];
          held    <= held + 2'd1;
          grp_err <= grp_err || bad_now;
        end
      end
    end
  end

endmodule

// ----- rtl/core/b64dd_queue.sv -----
module b64dd_queue import b64dd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t push_grp,
  input  logic pop,
  output grp_t pop_grp,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_grp = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/b64dd_back.sv -----
module b64dd_back import b64dd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  grp_t       q_grp,
  output logic       pop,
  output logic [7:0] data_byte,
  output logic       bad_symbol,
  output logic       run_end,
  output logic       message_end,
  output logic       byte_valid,
  input  logic       byte_stall
);

  grp_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       done;

  assign done = busy && !byte_stall && (idx == 2'd2);
  assign pop  = !q_empty && (!busy || done);

  assign byte_valid  = busy;
  assign bad_symbol  = cur.bad;
  assign run_end     = (idx == 2'd2);
  assign message_end = (idx == 2'd2) && cur.last;

  always_comb begin
    case (idx)
      2'd0:    data_byte = cur.byte0;
      2'd1:    data_byte = cur.byte1;
      default: data_byte = cur.byte2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (done) begin
        busy <= 1'b0;
        idx  <= '0;
      end else if (busy && !byte_stall) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/base64_dual_order_decoder_core.sv -----
// channel   direction  handshake              payload
// char      in         char_valid/char_stall  char_code, final_char
// byte      out        byte_valid/byte_stall  data_byte, bad_symbol, run_end, message_end
// cfg       in         cfg_write              cfg_index, cfg_data
//
// One character a cycle while the group queue is not full; a group leaves as three bytes.
// A group that a character closes is written into the group queue, then loaded into the byte stage.
// Sustained rate is bounded by the byte port: three bytes per group, the next taken as the last leaves.
// Synchronous reset clears configuration, group state and the queue.
// char_stall follows the group queue being full; byte_stall holds the current byte.
module base64_dual_order_decoder_core import b64dd_pkg::*; #(
  parameter int GROUP_COUNT_BITS = GROUP_COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               char_code,
  input  logic                     final_char,
  input  logic                     char_valid,
  output logic                     char_stall,
  output logic [7:0]               data_byte,
  output logic                     bad_symbol,
  output logic                     run_end,
  output logic                     message_end,
  output logic                     byte_valid,
  input  logic                     byte_stall,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic push;
  grp_t push_grp;
  logic q_full;
  logic q_empty;
  logic pop;
  grp_t pop_grp;

  b64dd_front #(
    .GROUP_COUNT_BITS(GROUP_COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .final_char (final_char),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_grp   (push_grp)
  );

  b64dd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64dd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_grp       (pop_grp),
    .pop         (pop),
    .data_byte   (data_byte),
    .bad_symbol  (bad_symbol),
    .run_end     (run_end),
    .message_end (message_end),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall)
  );

endmodule

// ----- tb/sv/b64dd_check_pkg.sv -----
`timescale 1ns / 1ps

package b64dd_check_pkg;
  import b64dd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       bad;
    logic       run_end;
    logic       msg_end;
  } byte_due_t;

  // Tracks the decoder's group state and the bytes it still owes.
  class decode_tracker;
    logic                            big_endian;
    logic [CFG_DATA_BITS-1:0]        req_bits;
    logic [17:0]                     acc;
    logic [1:0]                      held;
    logic [GROUP_COUNT_BITS_DEF-1:0] groups;
    logic                            grp_bad;
    byte_due_t                       bytes_due[$];
    int                              errors;

    function new();
      big_endian = 1'b0;
      req_bits   = '0;
      groups     = '0;
      errors     = 0;
      clear_group();
    endfunction

    function void clear_group();
      acc     = '0;
      held    = '0;
      grp_bad = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == CFG_ORDER) begin
        big_endian = val[0];
      end else begin
        req_bits = val;
      end
    endfunction

    // -1 for a character outside the alphabet
    static function int sextet_of(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "-") return 63;
      return -1;
    endfunction

    function void take_char(logic [7:0] c, logic fin);
      int          lim;
      int          v;
      int          i;
      logic [5:0]  s [4];
      logic [23:0] word;
      logic [7:0]  b [3];
      logic        last;
      byte_due_t   d;
      lim = (req_bits != 0) ? (int'(req_bits) + GROUP_BITS - 1) / GROUP_BITS : 0;
      if (lim != 0 && int'(groups) >= lim) begin
        if (fin) begin
          clear_group();
          groups = '0;
        end
        return;
      end
      v = sextet_of(c);
      if (v < 0) begin
        v = 0;
        grp_bad = 1'b1;
      end
      if (held != 2'd3 && !fin) begin
        acc = acc | (18'(v) << (6 * held));
        held = held + 2'd1;
        return;
      end
      for (i = 0; i < 4; i++) begin
        if (i < int'(held)) s[i] = acc[6*i +: 6];
        else if (i == int'(held)) s[i] = 6'(v);
        else s[i] = '0;
      end
      if (big_endian) begin
        word = {s[0], s[1], s[2], s[3]};
        b[0] = word[23:16];
        b[1] = word[15:8];
        b[2] = word[7:0];
      end else begin
        word = {s[3], s[2], s[1], s[0]};
        b[0] = word[7:0];
        b[1] = word[15:8];
        b[2] = word[23:16];
      end
      last = fin || (lim != 0 && int'(groups) + 1 >= lim);
      for (i = 0; i < 3; i++) begin
        d.data    = b[i];
        d.bad     = grp_bad;
        d.run_end = (i == 2);
        d.msg_end = (i == 2) && last;
        bytes_due.push_back(d);
      end
      clear_group();
      if (groups != '1) groups = groups + 1'b1;
      if (fin) groups = '0;
    endfunction

    function void match_byte(logic [7:0] data, logic bad, logic re, logic me);
      byte_due_t d;
      if (bytes_due.size() == 0) begin
        $error("unexpected byte: data_byte %0h", data);
        errors++;
        return;
      end
      d = bytes_due.pop_front();
      if (data !== d.data) begin
        $error("data_byte: expected %0h, actual %0h", d.data, data);
        errors++;
      end
      if (bad !== d.bad) begin
        $error("bad_symbol: expected %0b, actual %0b", d.bad, bad);
        errors++;
      end
      if (re !== d.run_end) begin
        $error("run_end: expected %0b, actual %0b", d.run_end, re);
        errors++;
      end
      if (me !== d.msg_end) begin
        $error("message_end: expected %0b, actual %0b", d.msg_end, me);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import b64dd_pkg::*;
  import b64dd_check_pkg::*;

  localparam int DRAIN_LAT = 4;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [7:0]               char_code = '0;
  logic                     final_char = 1'b0;
  logic                     char_valid = 1'b0;
  logic                     char_stall;
  logic [7:0]               data_byte;
  logic                     bad_symbol;
  logic                     run_end;
  logic                     message_end;
  logic                     byte_valid;
  logic                     byte_stall = 1'b0;
  logic                     cfg_write = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  decode_tracker tracker = new();
  bit            gap_on = 1'b1;
  bit            stall_on = 1'b1;
  int            stall_hold = 0;

  base64_dual_order_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .char_code   (char_code),
    .final_char  (final_char),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .data_byte   (data_byte),
    .bad_symbol  (bad_symbol),
    .run_end     (run_end),
    .message_end (message_end),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_alpha();
    int k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    if (k == 62) return "+";
    return "-";
  endfunction

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!stall_on || $urandom_range(0, 1) == 0) begin
      byte_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else begin
      byte_stall <= 1'b1;
      stall_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      tracker.match_byte(data_byte, bad_symbol, run_end, message_end);
    end
    if (!rst && char_valid && !char_stall) begin
      tracker.take_char(char_code, final_char);
    end
  end

  // called and returns at a falling edge; valid stays high for back-to-back requests
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_code  <= c;
    final_char <= fin;
    char_valid <= 1'b1;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_msg(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic drain();
    char_valid <= 1'b0;
    @(posedge clk);
    while (tracker.bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_LAT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int         sent;
    int         pauses;
    int         n;
    int         len;
    int         i;
    int         k;
    logic [7:0] c;
    sent   = 0;
    pauses = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // low-first, no limit: full group, bad final after two, lone bad final
    send_char("A", 1'b0);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char("+", 1'b0);
    send_char("-", 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
    drain();
    write_reg(CFG_ORDER, 16'd1);
    send_msg("TWFu");
    send_msg("QQ");
    drain();
    // one group limit, then dropped chars and a dropped final
    write_reg(CFG_REQ_BITS, 16'd24);
    send_msg("ABCDEFG");
    drain();
    write_reg(CFG_REQ_BITS, 16'hffff);
    write_reg(CFG_ORDER, 16'd0);
    send_msg("ab9");

    while (sent < 180) begin
      drain();
      gap_on   = ($urandom_range(0, 9) < 7);
      stall_on = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_ORDER, 16'($urandom_range(0, 1)));
      k = $urandom_range(0, 9);
      if (k < 4) write_reg(CFG_REQ_BITS, 16'd0);
      else if (k < 6) write_reg(CFG_REQ_BITS, 16'($urandom_range(1, 200)));
      else if (k == 6) write_reg(CFG_REQ_BITS, 16'hffff);
      else if (k == 7) write_reg(CFG_REQ_BITS, 16'($urandom));
      n = $urandom_range(2, 4);
      repeat (n) begin
        if ($urandom_range(0, 4) != 0) begin
          len = $urandom_range(1, 14);
          for (i = 0; i < len; i++) begin
            if (i == len / 2 && i > 0 && (pauses == 0 || $urandom_range(0, 15) == 0)) begin
              drain();
              pauses++;
            end
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_alpha();
            send_char(c, i == len - 1);
          end
        end else begin
          len = $urandom_range(1, 6);
          for (i = 0; i < len; i++) begin
            send_char(8'($urandom), $urandom_range(0, 3) == 0);
          end
        end
        sent += len;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.bytes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
